>>> rtl/census_transform_5x5_unit_macros.svh
// assertion macros for the census transform checker
// no dependencies; taken in by the checker file
`ifndef CENSUS_TRANSFORM_5X5_UNIT_MACROS_SVH
`define CENSUS_TRANSFORM_5X5_UNIT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define CT5_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("census checker: property violated");

// concurrent assertion on the block clock and reset
`define CT5_ASSERT(lbl, prop) \
  `CT5_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

>>> rtl/ct5_pkg.sv
// shared constants, types and the descriptor bit packing for the census transform
// no dependencies; used by the top level, the cell and the checker
package ct5_pkg;

  localparam int PIX_W          = 8;
  localparam int DESC_W         = 24;
  localparam int COL_W          = 11;
  localparam int ROW_W          = 12;
  localparam int WIN            = 5;
  localparam int CENTER_ROW     = 2;
  localparam int CENTER_COL     = 2;
  localparam int STORE_ROWS     = 4;

  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_W_W        = 12;
  localparam int CFG_H_W        = 13;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int MIN_WIDTH      = 5;
  localparam int MIN_HEIGHT     = 6;
  localparam int RST_WIDTH      = 640;
  localparam int RST_HEIGHT     = 480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_BIT_ORDER    = 2'd2
  } reg_idx_e;

  typedef enum logic {
    ORDER_ROW_MAJOR = 1'b0,
    ORDER_COL_MAJOR = 1'b1
  } order_e;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // gt holds one compare bit per window position, row r column k at r*WIN+k
  function automatic logic [DESC_W-1:0] census_pack(input logic [WIN*WIN-1:0] gt,
                                                     input order_e order);
    logic [DESC_W-1:0] res;
    res = '0;
    for (int a = 0; a < WIN; a++) begin
      for (int b = 0; b < WIN; b++) begin
        if (order == ORDER_COL_MAJOR) begin
          if (!(b == CENTER_ROW && a == CENTER_COL)) begin
            res[(a*WIN+b < CENTER_ROW*WIN+CENTER_COL) ? a*WIN+b : a*WIN+b-1] = gt[b*WIN+a];
          end
        end else begin
          if (!(a == CENTER_ROW && b == CENTER_COL)) begin
            res[(a*WIN+b < CENTER_ROW*WIN+CENTER_COL) ? a*WIN+b : a*WIN+b-1] = gt[a*WIN+b];
          end
        end
      end
    end
    return res;
  endfunction

endpackage

>>> rtl/census_transform_5x5_unit.sv
// census transform 5x5 top level; uses ct5_pkg, ct5_ram and ct5_cell
// after its pixel request a result passes the read stage, the window cells and the output register
// throughput: one pixel per cycle while the output is not stalled, set by the registered store read and window shift
// reset clears counters, write pointer, window cells and stage valids
// the row store is not cleared and needs no clearing pass
module census_transform_5x5_unit #(
  parameter int MAX_WIDTH  = ct5_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ct5_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ct5_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ct5_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ct5_pkg::PIX_W-1:0]       pixel_i,
  input  logic                            frame_start_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ct5_pkg::DESC_W-1:0]      descriptor_o,
  output logic [ct5_pkg::COL_W-1:0]       center_col_o,
  output logic [ct5_pkg::ROW_W-1:0]       center_row_o
);

  localparam int CNT_CW = $clog2(MAX_WIDTH);
  localparam int CNT_RW = $clog2(MAX_HEIGHT);
  localparam int EW     = $clog2(MAX_WIDTH + 1);
  localparam int EH     = $clog2(MAX_HEIGHT + 1);
  localparam int EWX    = EW + 1;
  localparam int EHX    = EH + 1;
  localparam int CWC    = (EW > ct5_pkg::CFG_W_W) ? EW : ct5_pkg::CFG_W_W;
  localparam int CHC    = (EH > ct5_pkg::CFG_H_W) ? EH : ct5_pkg::CFG_H_W;
  localparam int AW     = $clog2(ct5_pkg::STORE_ROWS * MAX_WIDTH);
  localparam int PW     = ct5_pkg::PIX_W;
  localparam int WIN    = ct5_pkg::WIN;
  localparam int NR     = ct5_pkg::STORE_ROWS;

  // configuration registers
  logic [ct5_pkg::CFG_W_W-1:0] image_width_q, image_width_d;
  logic [ct5_pkg::CFG_H_W-1:0] image_height_q, image_height_d;
  ct5_pkg::order_e             bit_order_q, bit_order_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    image_width_d  = image_width_q;
    image_height_d = image_height_q;
    bit_order_d    = bit_order_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ct5_pkg::REG_IMAGE_WIDTH:  image_width_d  = cfg_data_i[ct5_pkg::CFG_W_W-1:0];
        ct5_pkg::REG_IMAGE_HEIGHT: image_height_d = cfg_data_i[ct5_pkg::CFG_H_W-1:0];
        ct5_pkg::REG_BIT_ORDER:    bit_order_d    = ct5_pkg::order_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= ct5_pkg::CFG_W_W'(ct5_pkg::RST_WIDTH);
      image_height_q <= ct5_pkg::CFG_H_W'(ct5_pkg::RST_HEIGHT);
      bit_order_q    <= ct5_pkg::ORDER_ROW_MAJOR;
    end else begin
      image_width_q  <= image_width_d;
      image_height_q <= image_height_d;
      bit_order_q    <= bit_order_d;
    end
  end

  // clamped frame size
  logic [CWC-1:0] w_ext;
  logic [CHC-1:0] h_ext;
  logic [EW-1:0]  eff_w;
  logic [EH-1:0]  eff_h;

  assign w_ext = CWC'(image_width_q);
  assign h_ext = CHC'(image_height_q);

  always_comb begin
    if (w_ext < CWC'(ct5_pkg::MIN_WIDTH)) begin
      eff_w = EW'(ct5_pkg::MIN_WIDTH);
    end else if (w_ext > CWC'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(w_ext);
    end
    if (h_ext < CHC'(ct5_pkg::MIN_HEIGHT)) begin
      eff_h = EH'(ct5_pkg::MIN_HEIGHT);
    end else if (h_ext > CHC'(MAX_HEIGHT)) begin
      eff_h = EH'(MAX_HEIGHT);
    end else begin
      eff_h = EH'(h_ext);
    end
  end

  // stage handshake
  logic a_valid_q, a_valid_d;
  logic w_valid_q, w_valid_d;
  logic out_valid_q, out_valid_d;
  logic w_emit_q;
  logic o_free, w_go, w_free, a_go, a_free, accept;

  assign o_free     = !out_valid_q || out_ready_i;
  assign w_go       = w_valid_q && (!w_emit_q || o_free);
  assign w_free     = !w_valid_q || w_go;
  assign a_go       = a_valid_q && w_free;
  assign a_free     = !a_valid_q || a_go;
  assign in_ready_o = a_free;
  assign accept     = in_valid_i && a_free;

  always_comb begin
    a_valid_d   = a_free ? accept : a_valid_q;
    w_valid_d   = w_free ? a_go : w_valid_q;
    out_valid_d = o_free ? (w_go && w_emit_q) : out_valid_q;
  end

  // pixel position
  logic [CNT_CW-1:0] col_cnt_q, col_cnt_d;
  logic [CNT_RW-1:0] row_cnt_q, row_cnt_d;
  logic [EW-1:0]     cur_col, col_nxt;
  logic [EH-1:0]     cur_row, row_nxt;

  always_comb begin
    if (frame_start_i) begin
      cur_col = '0;
      cur_row = '0;
    end else begin
      cur_col = EW'(col_cnt_q);
      cur_row = EH'(row_cnt_q);
      if (cur_col >= eff_w) begin
        cur_col = '0;
        cur_row = cur_row + EH'(1);
      end
      if (cur_row >= eff_h) begin
        cur_row = '0;
      end
    end
    col_nxt   = cur_col + EW'(1);
    row_nxt   = cur_row + EH'(1);
    col_cnt_d = CNT_CW'(col_nxt);
    row_cnt_d = CNT_RW'(cur_row);
    if (col_nxt >= eff_w) begin
      col_cnt_d = '0;
      row_cnt_d = (row_nxt >= eff_h) ? '0 : CNT_RW'(row_nxt);
    end
  end

  // center position and emit decision
  logic           col_ge2, emit;
  logic [EHX-1:0] h_x, row_p1, row_p2;
  logic [EWX-1:0] ccol_x;
  logic [EH-1:0]  crow_x;
  logic [NR-1:0]  gate;
  logic           clear;

  assign col_ge2 = cur_col >= EW'(2);
  assign h_x     = EHX'(eff_h);
  assign row_p1  = EHX'(cur_row) + EHX'(1);
  assign row_p2  = EHX'(cur_row) + EHX'(2);

  always_comb begin
    if (col_ge2) begin
      emit   = (cur_row >= EH'(4)) && (row_p2 <= h_x);
      crow_x = cur_row - EH'(2);
      ccol_x = EWX'(cur_col) - EWX'(2);
    end else begin
      emit   = (cur_row >= EH'(5)) && (row_p1 <= h_x);
      crow_x = cur_row - EH'(3);
      ccol_x = EWX'(cur_col) + EWX'(eff_w) - EWX'(2);
    end
    for (int r = 0; r < NR; r++) begin
      gate[r] = cur_row >= EH'(NR - r);
    end
    clear = (cur_row == '0) && (cur_col == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      a_valid_q   <= 1'b0;
      w_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_cnt_q <= col_cnt_d;
        row_cnt_q <= row_cnt_d;
      end
      a_valid_q   <= a_valid_d;
      w_valid_q   <= w_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // row store: two banks hold the same stream, each serves two row taps
  logic [AW-1:0] wp_q, wp_d;
  logic [AW-1:0] w_a;
  logic [AW-1:0] raddr [NR];
  logic [PW-1:0] rdata [NR];

  assign wp_d     = wp_q + AW'(1);
  assign w_a      = AW'(eff_w);
  assign raddr[0] = wp_q - (w_a << 2);
  assign raddr[1] = wp_q - (w_a + (w_a << 1));
  assign raddr[2] = wp_q - (w_a << 1);
  assign raddr[3] = wp_q - w_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
    end else if (accept) begin
      wp_q <= wp_d;
    end
  end

  ct5_ram #(
    .AW (AW),
    .DW (PW)
  ) u_ram_lo (
    .clk_i     (clk_i),
    .we_i      (accept),
    .waddr_i   (wp_q),
    .wdata_i   (pixel_i),
    .re_i      (accept),
    .raddr_a_i (raddr[0]),
    .raddr_b_i (raddr[1]),
    .rdata_a_o (rdata[0]),
    .rdata_b_o (rdata[1])
  );

  ct5_ram #(
    .AW (AW),
    .DW (PW)
  ) u_ram_hi (
    .clk_i     (clk_i),
    .we_i      (accept),
    .waddr_i   (wp_q),
    .wdata_i   (pixel_i),
    .re_i      (accept),
    .raddr_a_i (raddr[2]),
    .raddr_b_i (raddr[3]),
    .rdata_a_o (rdata[2]),
    .rdata_b_o (rdata[3])
  );

  // read stage payload
  logic                      a_emit_q, a_clear_q;
  logic [NR-1:0]             a_gate_q;
  logic [PW-1:0]             a_pix_q;
  logic [ct5_pkg::COL_W-1:0] a_ccol_q, w_ccol_q;
  logic [ct5_pkg::ROW_W-1:0] a_crow_q, w_crow_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_emit_q  <= emit;
      a_clear_q <= clear;
      a_gate_q  <= gate;
      a_pix_q   <= pixel_i;
      a_ccol_q  <= ct5_pkg::COL_W'(ccol_x);
      a_crow_q  <= ct5_pkg::ROW_W'(crow_x);
    end
    if (a_go) begin
      w_emit_q <= a_emit_q;
      w_ccol_q <= a_ccol_q;
      w_crow_q <= a_crow_q;
    end
  end

  // window of cells
  logic [PW-1:0]        fed [WIN];
  logic [PW-1:0]        win_pix [WIN][WIN];
  logic [WIN*WIN-1:0]   gt;

  always_comb begin
    for (int r = 0; r < NR; r++) begin
      fed[r] = a_gate_q[r] ? rdata[r] : '0;
    end
    fed[WIN-1] = a_pix_q;
  end

  for (genvar r = 0; r < WIN; r++) begin : g_row
    for (genvar k = 0; k < WIN; k++) begin : g_col
      ct5_pkg::cell_ctl_t ctl;
      logic [PW-1:0]      din;
      if (k == WIN - 1) begin : g_edge
        assign ctl = '{shift: a_go, clear: 1'b0};
        assign din = fed[r];
      end else begin : g_inner
        assign ctl = '{shift: a_go, clear: a_clear_q};
        assign din = win_pix[r][k+1];
      end
      ct5_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctl_i    (ctl),
        .din_i    (din),
        .center_i (win_pix[ct5_pkg::CENTER_ROW][ct5_pkg::CENTER_COL]),
        .pix_o    (win_pix[r][k]),
        .gt_o     (gt[r*WIN+k])
      );
    end
  end

  // output register
  logic [ct5_pkg::DESC_W-1:0] descriptor_q;
  logic [ct5_pkg::COL_W-1:0]  center_col_q;
  logic [ct5_pkg::ROW_W-1:0]  center_row_q;

  always_ff @(posedge clk_i) begin
    if (w_go && w_emit_q) begin
      descriptor_q <= ct5_pkg::census_pack(gt, bit_order_q);
      center_col_q <= w_ccol_q;
      center_row_q <= w_crow_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign descriptor_o = descriptor_q;
  assign center_col_o = center_col_q;
  assign center_row_o = center_row_q;

endmodule

>>> rtl/ct5_ram.sv
// row store memory: one write port, two read ports with registered read data
// depends on nothing; instantiated by the census transform top level
module ct5_ram #(
  parameter int AW = 13,
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [DW-1:0] rdata_a_o,
  output logic [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

>>> rtl/ct5_cell.sv
// one window position: holds a pixel, shifts from its neighbor, compares to center
// depends on ct5_pkg
module ct5_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ct5_pkg::cell_ctl_t         ctl_i,
  input  logic [ct5_pkg::PIX_W-1:0]  din_i,
  input  logic [ct5_pkg::PIX_W-1:0]  center_i,
  output logic [ct5_pkg::PIX_W-1:0]  pix_o,
  output logic                       gt_o
);

  logic [ct5_pkg::PIX_W-1:0] pix_q;
  logic [ct5_pkg::PIX_W-1:0] pix_d;

  always_comb begin
    pix_d = pix_q;
    if (ctl_i.shift) begin
      pix_d = ctl_i.clear ? '0 : din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;
  assign gt_o  = pix_q > center_i;

endmodule

>>> rtl/ct5_checker.sv
// port-level checks for the census transform top level, attached by bind
// depends on ct5_pkg and census_transform_5x5_unit_macros.svh
`include "census_transform_5x5_unit_macros.svh"

module ct5_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [ct5_pkg::DESC_W-1:0]  descriptor_o,
  input logic [ct5_pkg::COL_W-1:0]   center_col_o,
  input logic [ct5_pkg::ROW_W-1:0]   center_row_o
);

  localparam int OUT_W = ct5_pkg::DESC_W + ct5_pkg::COL_W + ct5_pkg::ROW_W;

  logic [OUT_W-1:0] out_payload;

  assign out_payload = {descriptor_o, center_col_o, center_row_o};

  // no result right out of reset
  `CT5_ASSERT(a_no_out_after_reset, $rose(rst_ni) |-> !out_valid_o)

  // an empty output register never blocks a pixel request
  `CT5_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o)

  // a stalled result keeps its payload
  `CT5_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_payload))

  // centers above row two are never reported
  `CT5_ASSERT(a_row_min, out_valid_o |-> center_row_o >= ct5_pkg::ROW_W'(2))

endmodule

bind census_transform_5x5_unit ct5_checker u_ct5_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .descriptor_o (descriptor_o),
  .center_col_o (center_col_o),
  .center_row_o (center_row_o)
);

>>> tb/sv/census_transform_5x5_unit_test.sv
// self-checking testbench for census_transform_5x5_unit: drives pixel frames and config
// writes with random idling on both sides and checks every descriptor against its own model
// depends on ct5_pkg and the census_transform_5x5_unit rtl
`timescale 1ns / 1ps

module census_transform_5x5_unit_test;
  import ct5_pkg::*;

  localparam int STORE_DEPTH  = STORE_ROWS * MAX_WIDTH_DEF;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int RANDOM_ITEMS = 200;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [DESC_W-1:0] desc;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } census_res_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [PIX_W-1:0]      pixel_i;
  logic                  frame_start_i;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [DESC_W-1:0]     descriptor_o;
  logic [COL_W-1:0]      center_col_o;
  logic [ROW_W-1:0]      center_row_o;

  census_transform_5x5_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_i      (pixel_i),
    .frame_start_i(frame_start_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .descriptor_o (descriptor_o),
    .center_col_o (center_col_o),
    .center_row_o (center_row_o)
  );

  // model state
  logic [PIX_W-1:0]  row_store [STORE_DEPTH];
  int                store_wr;
  logic [PIX_W-1:0]  window_px [WIN][WIN];
  int                next_col;
  int                next_row;
  logic [CFG_W_W-1:0] reg_width;
  logic [CFG_H_W-1:0] reg_height;
  order_e            reg_order;
  census_res_t       pending_descriptors [$];

  int   error_count;
  int   pixels_sent;
  int   in_gap_mode;
  int   out_gap_mode;
  int   rx_hold;
  logic restart_frame;

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int cur_width();
    if (reg_width < MIN_WIDTH) return MIN_WIDTH;
    if (reg_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return int'(reg_width);
  endfunction

  function automatic int cur_height();
    if (reg_height < MIN_HEIGHT) return MIN_HEIGHT;
    if (reg_height > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
    return int'(reg_height);
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    int old_w;
    old_w = cur_width();
    case (idx)
      REG_IMAGE_WIDTH:  reg_width  = data[CFG_W_W-1:0];
      REG_IMAGE_HEIGHT: reg_height = data[CFG_H_W-1:0];
      REG_BIT_ORDER:    reg_order  = order_e'(data[0]);
      default: ;
    endcase
    // wider rows would reach store entries never written unless a new frame starts
    if (cur_width() > old_w) restart_frame = 1'b1;
  endfunction

  function automatic void predict_descriptor(input logic [PIX_W-1:0] pix, input logic sof);
    int w, h, row, col, d, rd, crow, ccol, bit_idx, r, k;
    logic [PIX_W-1:0] fed [WIN];
    census_res_t res;
    w = cur_width();
    h = cur_height();
    if (sof) begin
      row = 0;
      col = 0;
    end else begin
      row = next_row;
      col = next_col;
      if (col >= w) begin
        col = 0;
        row++;
      end
      if (row >= h) row = 0;
    end
    if (row == 0 && col == 0) begin
      foreach (window_px[i, j]) window_px[i][j] = '0;
    end
    for (int i = 0; i < STORE_ROWS; i++) begin
      d = (STORE_ROWS - i) * w;
      rd = (store_wr >= d) ? store_wr - d : store_wr + STORE_DEPTH - d;
      fed[i] = (row >= STORE_ROWS - i) ? row_store[rd] : '0;
    end
    fed[STORE_ROWS] = pix;
    row_store[store_wr] = pix;
    store_wr = (store_wr + 1 >= STORE_DEPTH) ? 0 : store_wr + 1;
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN - 1; j++) window_px[i][j] = window_px[i][j+1];
      window_px[i][WIN-1] = fed[i];
    end
    next_col = col + 1;
    next_row = row;
    if (next_col >= w) begin
      next_col = 0;
      next_row = row + 1;
      if (next_row >= h) next_row = 0;
    end
    if (col >= CENTER_COL) begin
      crow = row - CENTER_ROW;
      ccol = col - CENTER_COL;
    end else begin
      crow = row - CENTER_ROW - 1;
      ccol = col + w - CENTER_COL;
    end
    if (crow < CENTER_ROW || crow > h - STORE_ROWS) return;
    res.desc = '0;
    bit_idx = 0;
    for (int a = 0; a < WIN; a++) begin
      for (int b = 0; b < WIN; b++) begin
        r = (reg_order == ORDER_COL_MAJOR) ? b : a;
        k = (reg_order == ORDER_COL_MAJOR) ? a : b;
        if (!(r == CENTER_ROW && k == CENTER_COL)) begin
          if (window_px[r][k] > window_px[CENTER_ROW][CENTER_COL]) res.desc[bit_idx] = 1'b1;
          bit_idx++;
        end
      end
    end
    res.col = COL_W'(ccol);
    res.row = ROW_W'(crow);
    pending_descriptors.push_back(res);
  endfunction

  function automatic int pick_gap(input int mode);
    int p;
    if (mode == 0) return 0;
    p = $urandom_range(0, 99);
    if (p < ((mode == 1) ? 80 : 50)) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(12, 30);
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // request monitor, model update and result check
  always @(posedge clk_i) begin : check_results
    census_res_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) apply_reg_write(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) predict_descriptor(pixel_i, frame_start_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_descriptors.size() == 0) begin
          report_mismatch($sformatf("unexpected result desc %h col %0d row %0d",
                                    descriptor_o, center_col_o, center_row_o));
        end else begin
          want = pending_descriptors.pop_front();
          if (descriptor_o !== want.desc)
            report_mismatch($sformatf("descriptor %h, want %h (row %0d col %0d)",
                                      descriptor_o, want.desc, want.row, want.col));
          if (center_col_o !== want.col)
            report_mismatch($sformatf("center_col %0d, want %0d", center_col_o, want.col));
          if (center_row_o !== want.row)
            report_mismatch($sformatf("center_row %0d, want %0d", center_row_o, want.row));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rx_hold == 0) rx_hold = pick_gap(out_gap_mode);
    out_ready_i <= (rx_hold == 0);
    if (rx_hold > 0) rx_hold--;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic sof);
    int gap;
    gap = pick_gap(in_gap_mode);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_i       <= pix;
    frame_start_i <= sof | restart_frame;
    restart_frame = 1'b0;
    do @(posedge clk_i); while (!in_ready_o);
    pixels_sent++;
  endtask

  task automatic send_run(input int count, input bit sof_first, input int sof_odds);
    for (int i = 0; i < count; i++)
      send_pixel(PIX_W'($urandom),
                 (i == 0 && sof_first) || (sof_odds > 0 && $urandom_range(1, sof_odds) == 1));
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_descriptors.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // clamped minimum size, column-major order, extreme pixels around the first centers
  task automatic test_directed_small();
    logic [PIX_W-1:0] pix;
    write_reg(REG_IMAGE_WIDTH, 13'd0);
    write_reg(REG_IMAGE_HEIGHT, 13'd0);
    write_reg(REG_BIT_ORDER, 13'(ORDER_COL_MAJOR));
    in_gap_mode  = 0;
    out_gap_mode = 0;
    for (int i = 0; i < 25; i++) begin
      case (i)
        10:      pix = 8'h00;
        11:      pix = 8'hFF;
        12:      pix = 8'h80;
        default: pix = PIX_W'(i * 53);
      endcase
      send_pixel(pix, i == 0);
    end
    wait_drain();
  endtask

  // frames run into each other without frame_start, row-major order
  task automatic test_frame_overrun();
    write_reg(REG_IMAGE_WIDTH, 13'h1005);
    write_reg(REG_IMAGE_HEIGHT, 13'd6);
    write_reg(REG_BIT_ORDER, 13'h1FFE);
    in_gap_mode  = 1;
    out_gap_mode = 1;
    send_run(3 * 30 + 7, 1'b1, 0);
    wait_drain();
  endtask

  // shrink width and height while the counters sit beyond the new size
  task automatic test_size_change();
    write_reg(REG_IMAGE_WIDTH, 13'd12);
    write_reg(REG_IMAGE_HEIGHT, 13'd12);
    write_reg(REG_BIT_ORDER, 13'(ORDER_COL_MAJOR));
    in_gap_mode  = 2;
    out_gap_mode = 2;
    send_run(12 * 7 + 9, 1'b1, 0);
    wait_drain();
    write_reg(REG_IMAGE_WIDTH, 13'd6);
    send_run(20, 1'b0, 0);
    wait_drain();
    write_reg(REG_IMAGE_HEIGHT, 13'd6);
    send_run(40, 1'b0, 0);
    wait_drain();
  endtask

  // widest row and tallest frame via clamping, then a narrow row mid frame
  task automatic test_wide_frame();
    write_reg(REG_IMAGE_WIDTH, 13'h0FFF);
    write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
    in_gap_mode  = 0;
    out_gap_mode = 1;
    send_run(40, 1'b1, 0);
    wait_drain();
    write_reg(REG_IMAGE_WIDTH, 13'd7);
    send_run(50, 1'b0, 0);
    wait_drain();
  endtask

  task automatic test_random_frames();
    int start, kind, len;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) != 0)
        write_reg(REG_IMAGE_WIDTH, {1'($urandom_range(0, 1)),
                  12'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 12))});
      if ($urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 9) == 0)
          write_reg(REG_IMAGE_HEIGHT, 13'($urandom_range(4090, 8191)));
        else
          write_reg(REG_IMAGE_HEIGHT, 13'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 5)
                                                                       : $urandom_range(6, 10)));
      end
      if ($urandom_range(0, 1) != 0)
        write_reg(REG_BIT_ORDER, {12'($urandom), 1'($urandom_range(0, 1))});
      if ($urandom_range(0, 5) == 0) write_reg(REG_NONE, 13'($urandom));
      in_gap_mode  = $urandom_range(0, 2);
      out_gap_mode = $urandom_range(0, 2);
      len = cur_width() * cur_height();
      if (len > 150) len = 150;
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        repeat ($urandom_range(1, 2)) send_run(len, 1'b1, 0);
      end else if (kind == 7) begin
        send_run($urandom_range(1, len - 1), 1'b1, 0);
      end else if (kind == 8) begin
        send_run($urandom_range(20, 80), 1'b0, 8);
      end else begin
        send_run(len + $urandom_range(1, len), 1'b0, 0);
      end
      wait_drain();
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_IMAGE_WIDTH;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    pixel_i       <= '0;
    frame_start_i <= 1'b0;
    foreach (window_px[i, j]) window_px[i][j] = '0;
    store_wr      = 0;
    next_col      = 0;
    next_row      = 0;
    reg_width     = CFG_W_W'(RST_WIDTH);
    reg_height    = CFG_H_W'(RST_HEIGHT);
    reg_order     = ORDER_ROW_MAJOR;
    error_count   = 0;
    pixels_sent   = 0;
    in_gap_mode   = 0;
    out_gap_mode  = 0;
    rx_hold       = 0;
    restart_frame = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_small();
    test_frame_overrun();
    test_size_change();
    test_wide_frame();
    test_random_frames();

    wait_drain();
    if (error_count == 0) begin
      $display("census_transform_5x5_unit_test: done, clean");
    end else begin
      $display("census_transform_5x5_unit_test: done, errors");
    end
    $finish;
  end

  initial begin
    for (int c = 0; c < CYCLE_LIMIT; c++) @(posedge clk_i);
    $display("census_transform_5x5_unit_test: done, errors");
    $finish;
  end

endmodule
